>>> rtl/gesa_pkg.sv
// Shared types, constants and ROM entry functions for the Gaussian envelope block.
// No dependencies; used by every module of the block except gesa_div.
package gesa_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_NOISE  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CENTER = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_NYQ    = 3'd4;

	// Table selectors for the interpolator
	localparam int TBL_EXP  = 0;
	localparam int TBL_SINC = 1;

	// Fixed-point constants
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] LN2_Q30     = 64'd744261118;
	localparam logic [16:0] LOG2E_Q16   = 17'd94548;
	localparam logic [16:0] ONE_Q16     = 17'd65536;

	// Start-to-done latency, summed over the envelope, response and output sections
	localparam int LATENCY = 163;

	// Configuration register set
	typedef struct packed {
		logic [31:0] noise;
		logic [31:0] height;
		logic [23:0] center;
		logic [23:0] width;
		logic [23:0] nyq;
	} cfg_t;

	// sinc^2 entry for angle a (Q30): sin(a)/a series, squared
	function automatic logic [30:0] sinc2_entry(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] sum;
		logic [63:0] term;
		a2 = (a * a) >> 30;
		sum = ONE_Q30;
		term = ONE_Q30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return 31'((sum * sum) >> 30);
	endfunction

	// exp(-t) entry for t (Q30): Taylor series
	function automatic logic [30:0] exp_entry(input logic [63:0] t);
		logic [63:0] es;
		logic [63:0] et;
		es = ONE_Q30;
		et = ONE_Q30;
		for (int k = 1; k <= 14; k++) begin
			et = ((et * t) >> 30) / 64'(k);
			if (k % 2 == 1) begin
				es = es - et;
			end else begin
				es = es + et;
			end
		end
		return 31'(es);
	endfunction

endpackage

>>> rtl/gesa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on nothing; used by gesa_env and gesa_resp.
module gesa_div #(
	parameter int DW = 24,
	parameter int QW = 24,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quot,
	output logic [PW-1:0] out_side
);

	logic          vld_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] nq_s   [QW];
	logic [DW-1:0] den_s  [QW];
	logic [PW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          vld_in;
		logic [DW-1:0] rem_in;
		logic [QW-1:0] nq_in;
		logic [DW-1:0] den_in;
		logic [PW-1:0] side_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          take;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = in_rem;
			assign nq_in   = in_num;
			assign den_in  = in_den;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign nq_in   = nq_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
		end

		// shift in the next dividend bit, subtract if it fits
		always_comb begin
			trial = {rem_in, nq_in[QW-1]};
			diff  = trial - {1'b0, den_in};
			take  = (trial >= {1'b0, den_in});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? diff[DW-1:0] : trial[DW-1:0];
			nq_s[k]   <= {nq_in[QW-2:0], take};
			den_s[k]  <= den_in;
			side_s[k] <= side_in;
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quot  = nq_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

>>> rtl/gesa_interp.sv
// Four-stage table interpolator over a constant ROM of DEPTH+1 entries (Q30).
// Depends on gesa_pkg for the ROM entry functions.
module gesa_interp #(
	parameter int DEPTH = 256,
	parameter int KIND  = 0,
	parameter int PW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [16:0]   in_pos,
	input  logic [PW-1:0] in_side,
	output logic          out_valid,
	output logic [30:0]   out_val,
	output logic [PW-1:0] out_side
);
	import gesa_pkg::*;

	localparam int IW = $clog2(DEPTH + 1);

	logic [30:0] rom [DEPTH+1];

	// constant table contents
	for (genvar i = 0; i <= DEPTH; i++) begin : g_rom
		if (KIND == TBL_EXP) begin : g_exp
			localparam logic [63:0] ARG = LN2_Q30 * 64'(i) / 64'(DEPTH);
			assign rom[i] = exp_entry(ARG);
		end else begin : g_sinc
			localparam logic [63:0] ARG = HALF_PI_Q30 * 64'(i) / 64'(DEPTH);
			assign rom[i] = sinc2_entry(ARG);
		end
	end

	logic [16+IW:0] pos;
	logic [IW:0]    idx_full;
	logic           clamp;
	logic [IW-1:0]  lo_idx_s1, hi_idx_s1;
	logic [15:0]    fr_s1, fr_s2;
	logic [30:0]    lo_s2, hi_s2, lo_s3, step_s3, val_s4;
	logic           down_s3;
	logic           vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PW-1:0]  side_s1, side_s2, side_s3, side_s4;
	logic [30:0]    delta;
	logic [46:0]    prod;

	// table position: index and fraction
	always_comb begin
		pos      = (17 + IW)'(in_pos) * (17 + IW)'(DEPTH);
		idx_full = pos[16+IW:16];
		clamp    = (idx_full >= (IW + 1)'(DEPTH));
	end

	// difference between neighbors, scaled by the fraction
	always_comb begin
		delta = (lo_s2 >= hi_s2) ? (lo_s2 - hi_s2) : (hi_s2 - lo_s2);
		prod  = 47'(delta) * 47'(fr_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: addresses
		lo_idx_s1 <= clamp ? IW'(DEPTH) : idx_full[IW-1:0];
		hi_idx_s1 <= clamp ? IW'(DEPTH) : (idx_full[IW-1:0] + IW'(1));
		fr_s1     <= clamp ? 16'd0 : pos[15:0];
		side_s1   <= in_side;
		// stage 2: ROM reads
		lo_s2     <= rom[lo_idx_s1];
		hi_s2     <= rom[hi_idx_s1];
		fr_s2     <= fr_s1;
		side_s2   <= side_s1;
		// stage 3: step size
		lo_s3     <= lo_s2;
		step_s3   <= prod[46:16];
		down_s3   <= (lo_s2 >= hi_s2);
		side_s3   <= side_s2;
		// stage 4: move toward the upper neighbor
		val_s4    <= down_s3 ? (lo_s3 - step_s3) : (lo_s3 + step_s3);
		side_s4   <= side_s3;
	end

	assign out_valid = vld_s4;
	assign out_val   = val_s4;
	assign out_side  = side_s4;

endmodule

>>> rtl/gesa_env.sv
// Envelope section: distance ratio, exp lookup and height scaling, plus prior sum.
// Depends on gesa_pkg, gesa_div and gesa_interp.
module gesa_env #(
	parameter int DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gesa_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  logic [23:0]     in_freq,
	input  logic [31:0]     in_prior,
	output logic            out_valid,
	output logic [23:0]     out_freq,
	output logic [32:0]     out_sum
);
	import gesa_pkg::*;

	logic [23:0] sig_e, freq_dist;
	logic        far;

	logic        vld_s1;
	logic [23:0] d_s1, sig_s1, freq_s1;
	logic [31:0] prior_s1;
	logic        far_s1;

	logic        dq_vld;
	logic [23:0] dq_quot;
	logic [56:0] dq_side;

	logic        vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [30:0] x_s2;
	logic [56:0] side_s2;
	logic [47:0] qq, yy;
	logic [31:0] y;
	logic        zero_s3;
	logic [4:0]  n_s3;
	logic [15:0] p_s3;
	logic [23:0] freq_s3;
	logic [31:0] prior_s3;

	logic        ip_vld;
	logic [30:0] ip_val;
	logic [61:0] ip_side;
	logic        ip_zero;
	logic [4:0]  ip_n;
	logic [23:0] ip_freq;
	logic [31:0] ip_prior;

	logic [30:0] g_s4;
	logic [23:0] freq_s4, freq_s5, freq_s6;
	logic [31:0] prior_s4, prior_s5;
	logic [62:0] hp;
	logic [31:0] term_s5;
	logic [32:0] sum_s6;

	// distance from the center and out-of-range check
	always_comb begin
		sig_e     = (cfg.width == 24'd0) ? 24'd1 : cfg.width;
		freq_dist = (cfg.center > in_freq) ? (cfg.center - in_freq) : (in_freq - cfg.center);
		far       = ({8'd0, freq_dist} >= {sig_e, 8'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_s1     <= freq_dist;
		sig_s1   <= sig_e;
		far_s1   <= far;
		freq_s1  <= in_freq;
		prior_s1 <= in_prior;
	end

	// r = dist * 2^16 / sigma
	gesa_div #(.DW(24), .QW(24), .PW(57)) u_div_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_rem    ({8'd0, d_s1[23:8]}),
		.in_num    ({d_s1[7:0], 16'd0}),
		.in_den    (sig_s1),
		.in_side   ({far_s1, freq_s1, prior_s1}),
		.out_valid (dq_vld),
		.out_quot  (dq_quot),
		.out_side  (dq_side)
	);

	// r^2/2 then scale by log2(e)
	always_comb begin
		qq = 48'(dq_quot) * 48'(dq_quot);
		yy = 48'(x_s2) * 48'(LOG2E_Q16);
		y  = yy[47:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= dq_vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s2     <= qq[47:17];
		side_s2  <= dq_side;
		zero_s3  <= side_s2[56] || (y[31:16] > 16'd30);
		n_s3     <= y[20:16];
		p_s3     <= y[15:0];
		freq_s3  <= side_s2[55:32];
		prior_s3 <= side_s2[31:0];
	end

	// 2^-frac(y) from the exp table
	gesa_interp #(.DEPTH(DEPTH), .KIND(TBL_EXP), .PW(62)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_pos    ({1'b0, p_s3}),
		.in_side   ({zero_s3, n_s3, freq_s3, prior_s3}),
		.out_valid (ip_vld),
		.out_val   (ip_val),
		.out_side  (ip_side)
	);

	assign {ip_zero, ip_n, ip_freq, ip_prior} = ip_side;

	assign hp = 63'(cfg.height) * 63'(g_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= ip_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// integer part of y as a right shift, height scaling, prior sum
	always_ff @(posedge clk) begin
		g_s4     <= ip_zero ? 31'd0 : (ip_val >> ip_n);
		freq_s4  <= ip_freq;
		prior_s4 <= ip_prior;
		term_s5  <= hp[61:30];
		freq_s5  <= freq_s4;
		prior_s5 <= prior_s4;
		sum_s6   <= {1'b0, prior_s5} + {1'b0, term_s5};
		freq_s6  <= freq_s5;
	end

	assign out_valid = vld_s6;
	assign out_freq  = freq_s6;
	assign out_sum   = sum_s6;

endmodule

>>> rtl/gesa_resp.sv
// Response section: u = f/nyquist, folded sinc^2 lookup, division by u^2 above Nyquist.
// Depends on gesa_pkg, gesa_div and gesa_interp.
module gesa_resp #(
	parameter int DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gesa_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  logic [23:0]     in_freq,
	input  logic [32:0]     in_sum,
	output logic            out_valid,
	output logic [32:0]     out_sum,
	output logic [30:0]     out_resp
);
	import gesa_pkg::*;

	logic        vld_s1;
	logic [23:0] freq_s1, nyq_s1;
	logic [32:0] sum_s1;

	logic        du_vld;
	logic [39:0] du_quot;
	logic [32:0] du_side;

	logic [16:0] v, w;
	logic        vld_s2;
	logic [39:0] u_s2;
	logic [16:0] w_s2;
	logic        big_s2;
	logic [32:0] sum_s2;

	logic        ip_vld;
	logic [30:0] ip_val;
	logic [90:0] ip_side;
	logic        ip_big;
	logic [39:0] ip_u;
	logic [16:0] ip_w;
	logic [32:0] ip_sum;

	logic        vld_s3, vld_s4;
	logic [47:0] sw_s3;
	logic [30:0] s_s3, s_s4;
	logic [16:0] w_s3;
	logic        big_s3, big_s4;
	logic [39:0] u_s3, u_s4;
	logic [32:0] sum_s3, sum_s4;
	logic [64:0] xw;
	logic [62:0] x_s4;

	logic         da_vld;
	logic [46:0]  da_quot;
	logic [104:0] da_side;
	logic         da_big;
	logic [39:0]  da_u;
	logic [30:0]  da_s;
	logic [32:0]  da_sum;

	logic        db_vld;
	logic [30:0] db_quot;
	logic [64:0] db_side;
	logic        db_big;
	logic [30:0] db_s;
	logic [32:0] db_sum;

	logic        vld_s5;
	logic [30:0] resp_s5;
	logic [32:0] sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		freq_s1 <= in_freq;
		sum_s1  <= in_sum;
		nyq_s1  <= (cfg.nyq == 24'd0) ? 24'd1 : cfg.nyq;
	end

	// u = f * 2^16 / nyquist
	gesa_div #(.DW(24), .QW(40), .PW(33)) u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_rem    (24'd0),
		.in_num    ({freq_s1, 16'd0}),
		.in_den    (nyq_s1),
		.in_side   (sum_s1),
		.out_valid (du_vld),
		.out_quot  (du_quot),
		.out_side  (du_side)
	);

	// fold u into [0, 1.0]; equals u itself when u <= 1.0
	always_comb begin
		v = du_quot[16:0];
		w = (v <= ONE_Q16) ? v : 17'(18'd131072 - {1'b0, v});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= du_vld;
		end
	end

	always_ff @(posedge clk) begin
		u_s2   <= du_quot;
		w_s2   <= w;
		big_s2 <= (du_quot > 40'(ONE_Q16));
		sum_s2 <= du_side;
	end

	gesa_interp #(.DEPTH(DEPTH), .KIND(TBL_SINC), .PW(91)) u_sinc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_pos    (w_s2),
		.in_side   ({big_s2, u_s2, w_s2, sum_s2}),
		.out_valid (ip_vld),
		.out_val   (ip_val),
		.out_side  (ip_side)
	);

	assign {ip_big, ip_u, ip_w, ip_sum} = ip_side;

	// s * w * w, one multiply per stage
	assign xw = 65'(sw_s3) * 65'(w_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= ip_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sw_s3  <= 48'(ip_val) * 48'(ip_w);
		s_s3   <= ip_val;
		w_s3   <= ip_w;
		big_s3 <= ip_big;
		u_s3   <= ip_u;
		sum_s3 <= ip_sum;
		x_s4   <= xw[62:0];
		s_s4   <= s_s3;
		big_s4 <= big_s3;
		u_s4   <= u_s3;
		sum_s4 <= sum_s3;
	end

	// first division by u
	gesa_div #(.DW(40), .QW(47), .PW(105)) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_rem    ({24'd0, x_s4[62:47]}),
		.in_num    (x_s4[46:0]),
		.in_den    (u_s4),
		.in_side   ({big_s4, u_s4, s_s4, sum_s4}),
		.out_valid (da_vld),
		.out_quot  (da_quot),
		.out_side  (da_side)
	);

	assign {da_big, da_u, da_s, da_sum} = da_side;

	// second division by u
	gesa_div #(.DW(40), .QW(31), .PW(65)) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (da_vld),
		.in_rem    ({24'd0, da_quot[46:31]}),
		.in_num    (da_quot[30:0]),
		.in_den    (da_u),
		.in_side   ({da_big, da_s, da_sum}),
		.out_valid (db_vld),
		.out_quot  (db_quot),
		.out_side  (db_side)
	);

	assign {db_big, db_s, db_sum} = db_side;

	// pick the folded form above Nyquist
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= db_vld;
		end
	end

	always_ff @(posedge clk) begin
		resp_s5 <= db_big ? db_quot : db_s;
		sum_s5  <= db_sum;
	end

	assign out_valid = vld_s5;
	assign out_sum   = sum_s5;
	assign out_resp  = resp_s5;

endmodule

>>> rtl/gaussian_envelope_sinc_apodized_model_core.sv
// Top level: configuration registers, envelope and response sections, output stage.
// Depends on gesa_pkg, gesa_env and gesa_resp.
//
// Channel   Direction  Handshake          Payload
// request   in         start & !busy      frequency, prior_prediction
// result    out        done (one cycle)   prediction, saturated
// config    in         cfg_wr_en          cfg_addr, cfg_data
//
// One request per clock; busy never rises, so start may be held high every cycle.
// The latency from request to done is set by the four pipelined restoring dividers
// (24 + 40 + 47 + 31 stages) and the arithmetic stages between them.
// The receiver takes each result in its done cycle; nothing in the pipeline stalls.
// Reset clears the valid bits and loads the register defaults; data is not reset.
module gaussian_envelope_sinc_apodized_model_core #(
	parameter int APPROX_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] frequency,
	input  logic [31:0] prior_prediction,
	output logic        done,
	output logic [31:0] prediction,
	output logic        saturated,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);
	import gesa_pkg::*;

	cfg_t        cfg_q;
	logic        env_vld;
	logic [23:0] env_freq;
	logic [32:0] env_sum;
	logic        rsp_vld;
	logic [32:0] rsp_sum;
	logic [30:0] rsp_val;
	logic [63:0] prod;
	logic        vld_s1, vld_s2;
	logic [33:0] scaled_s1;
	logic [34:0] total;
	logic [31:0] pred_s2;
	logic        sat_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise  <= 32'd0;
			cfg_q.height <= 32'd0;
			cfg_q.center <= 24'd0;
			cfg_q.width  <= 24'd1024;
			cfg_q.nyq    <= 24'd290009;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_NOISE:  cfg_q.noise  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_CENTER: cfg_q.center <= cfg_data[23:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data[23:0];
				REG_NYQ:    cfg_q.nyq    <= cfg_data[23:0];
				default:    ;
			endcase
		end
	end

	assign busy = 1'b0;

	gesa_env #(.DEPTH(APPROX_TABLE_DEPTH)) u_env (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (start),
		.in_freq   (frequency),
		.in_prior  (prior_prediction),
		.out_valid (env_vld),
		.out_freq  (env_freq),
		.out_sum   (env_sum)
	);

	gesa_resp #(.DEPTH(APPROX_TABLE_DEPTH)) u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (env_vld),
		.in_freq   (env_freq),
		.in_sum    (env_sum),
		.out_valid (rsp_vld),
		.out_sum   (rsp_sum),
		.out_resp  (rsp_val)
	);

	// apply the response, add the noise floor, clip
	always_comb begin
		prod  = 64'(rsp_sum) * 64'(rsp_val);
		total = {1'b0, scaled_s1} + {3'd0, cfg_q.noise};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= rsp_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		scaled_s1 <= prod[63:30];
		sat_s2    <= |total[34:32];
		pred_s2   <= (|total[34:32]) ? 32'hFFFF_FFFF : total[31:0];
	end

	assign done       = vld_s2;
	assign prediction = pred_s2;
	assign saturated  = sat_s2;

endmodule

>>> rtl/gesa_checker.sv
// Port-level checks for the Gaussian envelope core, bound to the top level.
// Depends on gesa_pkg for the latency figure.
module gesa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] prediction,
	input logic        saturated
);
	import gesa_pkg::*;

	logic [7:0] since_rst_q;

	// cycles since reset release, saturating at the latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_rst_q <= 8'd0;
		end else if (since_rst_q != 8'(LATENCY)) begin
			since_rst_q <= since_rst_q + 8'd1;
		end
	end

	// each request comes back exactly once, after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(since_rst_q == 8'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match request latency");

	// a clipped result reads full scale
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (prediction == 32'hFFFF_FFFF))
		else $error("saturated result is not full scale");

	// the pipeline never refuses a request
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start) |-> !busy)
		else $error("busy raised while streaming");

endmodule

bind gaussian_envelope_sinc_apodized_model_core gesa_checker u_gesa_checker (.*);

>>> tb/gaussian_envelope_sinc_apodized_model_core_tb.sv
// Testbench for the Gaussian envelope / sinc^2 apodization core: directed and random
// requests checked against an in-bench fixed-point predictor. Depends on gesa_pkg.
module gaussian_envelope_sinc_apodized_model_core_tb;
	import gesa_pkg::*;

	typedef longint unsigned u64_t;
	typedef struct {
		logic [31:0] prediction;
		logic        saturated;
	} bin_result_t;

	localparam int TAB_DEPTH = 256;
	localparam logic [31:0] FULL32 = 32'hFFFF_FFFF;
	localparam logic [23:0] FULL24 = 24'hFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [23:0] frequency;
	logic [31:0] prior_prediction;
	logic        done;
	logic [31:0] prediction;
	logic        saturated;
	logic        cfg_wr_en;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_data;

	// predictor copy of the registers and the two tables
	cfg_t        model_cfg;
	u64_t        exp_tab [0:TAB_DEPTH];
	u64_t        sinc_tab [0:TAB_DEPTH];
	bin_result_t pending_bins [$];
	bit          failed;
	int          idle_pct;

	gaussian_envelope_sinc_apodized_model_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.frequency(frequency), .prior_prediction(prior_prediction),
		.done(done), .prediction(prediction), .saturated(saturated),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// exp(-j*ln2/D) and sinc^2(pi/2*i/D) series, floored in Q30
	task automatic build_tables();
		u64_t ang, ang2, ssum, sterm, t, esum, eterm;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			ang = u64_t'(HALF_PI_Q30) * u64_t'(i) / TAB_DEPTH;
			ang2 = (ang * ang) >> 30;
			ssum = ONE_Q30;
			sterm = ONE_Q30;
			for (int k = 1; k <= 12; k++) begin
				sterm = ((sterm * ang2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
				ssum = (k % 2) ? ssum - sterm : ssum + sterm;
			end
			sinc_tab[i] = (ssum * ssum) >> 30;
			t = u64_t'(LN2_Q30) * u64_t'(i) / TAB_DEPTH;
			esum = ONE_Q30;
			eterm = ONE_Q30;
			for (int k = 1; k <= 14; k++) begin
				eterm = ((eterm * t) >> 30) / u64_t'(k);
				esum = (k % 2) ? esum - eterm : esum + eterm;
			end
			exp_tab[i] = esum;
		end
	endtask

	// linear interpolation at a Q16 position in [0,1]
	function automatic u64_t table_lookup(int sel, u64_t pos_q16);
		u64_t pos, idx, fr, lo, hi;
		pos = pos_q16 * TAB_DEPTH;
		idx = pos >> 16;
		fr = pos & 64'hFFFF;
		if (idx >= TAB_DEPTH)
			return (sel == TBL_EXP) ? exp_tab[TAB_DEPTH] : sinc_tab[TAB_DEPTH];
		lo = (sel == TBL_EXP) ? exp_tab[idx] : sinc_tab[idx];
		hi = (sel == TBL_EXP) ? exp_tab[idx + 1] : sinc_tab[idx + 1];
		if (lo >= hi)
			return lo - (((lo - hi) * fr) >> 16);
		return lo + (((hi - lo) * fr) >> 16);
	endfunction

	// Gaussian term added to the prior, Q16.16
	function automatic u64_t gauss_term(u64_t f);
		u64_t ctr, sig, d, q, x, y, n, g;
		ctr = model_cfg.center;
		sig = model_cfg.width;
		d = (ctr > f) ? ctr - f : f - ctr;
		if (sig == 0)
			sig = 1;
		q = (d << 16) / sig;
		if (q >= (64'd1 << 24))
			return 0;
		x = (q * q) >> 17;
		y = (x * u64_t'(LOG2E_Q16)) >> 16;
		n = y >> 16;
		if (n > 30)
			return 0;
		g = table_lookup(TBL_EXP, y & 64'hFFFF) >> n;
		return (u64_t'(model_cfg.height) * g) >> 30;
	endfunction

	// apodization response, Q30; folded above Nyquist
	function automatic u64_t apod_response(u64_t f);
		u64_t nyq, u, v, w, s;
		nyq = model_cfg.nyq;
		if (nyq == 0)
			nyq = 1;
		u = (f << 16) / nyq;
		if (u <= u64_t'(ONE_Q16))
			return table_lookup(TBL_SINC, u);
		v = u & 64'h1FFFF;
		w = (v <= u64_t'(ONE_Q16)) ? v : 2 * u64_t'(ONE_Q16) - v;
		s = table_lookup(TBL_SINC, w);
		return ((s * w * w) / u) / u;
	endfunction

	function automatic bin_result_t predict_bin(logic [23:0] f, logic [31:0] prior);
		u64_t sum, total;
		bin_result_t r;
		sum = u64_t'(prior) + gauss_term(u64_t'(f));
		total = ((sum * apod_response(u64_t'(f))) >> 30) + u64_t'(model_cfg.noise);
		r.saturated = (total > u64_t'(FULL32));
		r.prediction = r.saturated ? FULL32 : total[31:0];
		return r;
	endfunction

	// accept requests and check results at the rising edge
	always @(posedge clk) begin
		bin_result_t exp_r;
		if (arst_n && start && !busy)
			pending_bins.push_back(predict_bin(frequency, prior_prediction));
		if (arst_n && done) begin
			if (pending_bins.size() == 0) begin
				$error("unexpected result: prediction=%h saturated=%b", prediction, saturated);
				failed = 1'b1;
			end else begin
				exp_r = pending_bins.pop_front();
				if (prediction !== exp_r.prediction) begin
					$error("prediction: expected %h actual %h", exp_r.prediction, prediction);
					failed = 1'b1;
				end
				if (saturated !== exp_r.saturated) begin
					$error("saturated: expected %b actual %b", exp_r.saturated, saturated);
					failed = 1'b1;
				end
			end
		end
	end

	// one request; start stays high until the caller idles
	task automatic send_bin(logic [23:0] f, logic [31:0] prior);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		frequency = f;
		prior_prediction = prior;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_bins.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		case (idx)
			REG_NOISE:  model_cfg.noise = val;
			REG_HEIGHT: model_cfg.height = val;
			REG_CENTER: model_cfg.center = val[23:0];
			REG_WIDTH:  model_cfg.width = val[23:0];
			REG_NYQ:    model_cfg.nyq = val[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_model(logic [31:0] noise, logic [31:0] height, logic [23:0] ctr,
			logic [23:0] sig, logic [23:0] nyq);
		wait_drained();
		write_reg(REG_NOISE, noise);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_CENTER, {8'd0, ctr});
		write_reg(REG_WIDTH, {8'd0, sig});
		write_reg(REG_NYQ, {8'd0, nyq});
	endtask

	// reset defaults: height 0, so only the prior, the response and noise matter
	task automatic test_defaults();
		send_bin(24'd0, 32'h0001_0000);
		send_bin(24'd290009, FULL32);
		send_bin(FULL24, 32'h1234_5678);
	endtask

	// extremes and special cases
	task automatic test_directed();
		set_model(32'd0, FULL32, 24'd100000, 24'd4096, 24'd200000);
		send_bin(24'd100000, 32'd0);        // at numax
		send_bin(24'd0, 32'd0);             // zero frequency, response 1.0
		send_bin(24'd0, FULL32);            // full-scale prior, result at full scale without saturation
		send_bin(FULL24, FULL32);
		send_bin(24'd200000, 32'hAAAA_AAAA); // exactly Nyquist
		send_bin(24'd400000, 32'h5555_5555); // response zero at 2x Nyquist
		send_bin(24'd600000, 32'h0000_FFFF);
		send_bin(24'd101000, 32'd0);
		send_bin(24'd140000, 32'd0);        // far from numax
		set_model(FULL32, FULL32, FULL24, 24'd0, 24'd0); // zero width and Nyquist
		send_bin(FULL24, 32'd0);
		send_bin(24'hFF_FFFE, 32'd0);
		send_bin(24'd0, 32'd0);
		set_model(32'h0001_0000, 32'h0100_0000, 24'd0, FULL24, FULL24);
		send_bin(24'd0, 32'd0);
		send_bin(FULL24, FULL32);
		send_bin(24'h80_0000, 32'h8000_0000);
		send_bin(24'd1, 32'd1);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return FULL32;
			2: return $urandom_range(0, 32'h00FF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// random configuration, then mostly bins near numax and Nyquist multiples
	task automatic test_random_phase(int n_bins);
		logic [23:0] ctr, sig, nyq, f;
		logic [31:0] prior;
		int unsigned span;
		ctr = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h10_0000));
		sig = $urandom_range(4) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h2_0000));
		nyq = $urandom_range(4) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h8_0000));
		set_model(pick32(), pick32(), ctr, sig, nyq);
		for (int i = 0; i < n_bins; i++) begin
			span = 4 * int'(sig) + 1;
			case ($urandom_range(9))
				0, 1, 2, 3, 4: f = ctr + 24'($urandom_range(0, span)) - 24'(span / 2);
				5, 6: f = nyq * 24'($urandom_range(0, 4)) + 24'($urandom_range(0, 255))
					- 24'd128;
				default: f = 24'($urandom);
			endcase
			prior = $urandom_range(2) == 0 ? pick32() : $urandom_range(0, 32'h0FFF_FFFF);
			send_bin(f, prior);
		end
	endtask

	initial begin
		failed = 1'b0;
		idle_pct = 32;
		arst_n = 1'b0;
		start = 1'b0;
		frequency = '0;
		prior_prediction = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = REG_NOISE;
		cfg_data = '0;
		model_cfg = '{noise: 32'd0, height: 32'd0, center: 24'd0, width: 24'd1024,
			nyq: 24'd290009};
		build_tables();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_directed();
		for (int p = 0; p < 18; p++) begin
			idle_pct = (p < 6) ? 32 : (p < 12) ? 52 : 0;
			test_random_phase(100);
		end
		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);
		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/gesa_pkg.sv
rtl/gesa_div.sv
rtl/gesa_interp.sv
rtl/gesa_env.sv
rtl/gesa_resp.sv
rtl/gaussian_envelope_sinc_apodized_model_core.sv
rtl/gesa_checker.sv
tb/gaussian_envelope_sinc_apodized_model_core_tb.sv
